// ----- sv/lsfc_pkg.sv -----
// Package with shared types and constants of the level-of-detail fade controller.
package lsfc_pkg;

    // Fade mode codes held per object.
    localparam logic [1:0] MODE_OPAQUE    = 2'd0;
    localparam logic [1:0] MODE_FADE_IN   = 2'd1;
    localparam logic [1:0] MODE_FADE_OUT  = 2'd2;
    localparam logic [1:0] MODE_INVISIBLE = 2'd3;

    // Visibility action codes.
    localparam logic [1:0] VIS_NONE = 2'd0;
    localparam logic [1:0] VIS_SHOW = 2'd1;
    localparam logic [1:0] VIS_HIDE = 2'd2;

    // Material action codes.
    localparam logic [1:0] MAT_NONE    = 2'd0;
    localparam logic [1:0] MAT_FADE    = 2'd1;
    localparam logic [1:0] MAT_RESTORE = 2'd2;

    // Notification codes.
    localparam logic [1:0] NOTE_NONE   = 2'd0;
    localparam logic [1:0] NOTE_SHOWN  = 2'd1;
    localparam logic [1:0] NOTE_HIDDEN = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_THR0       = 3'd0;
    localparam logic [2:0] REG_THR1       = 3'd1;
    localparam logic [2:0] REG_THR2       = 3'd2;
    localparam logic [2:0] REG_THR3       = 3'd3;
    localparam logic [2:0] REG_MESH_MASK  = 3'd4;
    localparam logic [2:0] REG_LEVEL_CNT  = 3'd5;
    localparam logic [2:0] REG_FADE_SCALE = 3'd6;
    localparam logic [2:0] REG_ALPHA_EN   = 3'd7;

    localparam logic [31:0] BYTE_REPLICATE = 32'h0101_0101;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [31:0] RGB_MASK       = 32'h00FF_FFFF;
    localparam logic [7:0]  FADE_FULL      = 8'hFF;

    // Word handed from the front part to the back part through the queue.
    typedef struct packed {
        logic [5:0]  index;
        logic        active;     // group visible and index in range
        logic        has_level;
        logic [1:0]  level;
        logic        mesh_level; // chosen level has a mesh
        logic [31:0] now_ms;
        logic        is_animated;
        logic [4:0]  material;
    } t_job;

    // Result word.
    typedef struct packed {
        logic [5:0]  index;
        logic        swap_mesh;
        logic [1:0]  new_level;
        logic [1:0]  vis_action;
        logic        write_color;
        logic [31:0] color;
        logic [1:0]  mat_action;
        logic [4:0]  mat_value;
        logic [1:0]  notify;
    } t_result;

endpackage

// ----- sv/lsfc_ram.sv -----
// Generic single-port RAM with registered read.
module lsfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write first is not needed: read data shows the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- sv/lsfc_front.sv -----
// Front part: distance calculation and level choice over a few stages.
module lsfc_front
    import lsfc_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int MAX_LEVELS  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_object_index,
    input  logic [31:0] i_now_ms,
    input  logic signed [15:0] i_camera_x,
    input  logic signed [15:0] i_camera_y,
    input  logic signed [15:0] i_camera_z,
    input  logic signed [15:0] i_object_x,
    input  logic signed [15:0] i_object_y,
    input  logic signed [15:0] i_object_z,
    input  logic        i_is_animated,
    input  logic [4:0]  i_object_material,
    input  logic        i_group_visible,
    input  logic [15:0] i_thr [4],
    input  logic [3:0]  i_mesh_mask,
    input  logic [2:0]  i_level_count,
    output logic        o_job_valid,
    input  logic        i_job_stall,
    output t_job        o_job
);

    // Step codes of the front sequencer.
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_CMP  = 2'd2;
    localparam logic [1:0] F_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    t_job        r_job;
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [33:0] r_sq [3];
    logic [35:0] r_d2;
    logic [2:0]  r_lvl_idx; // level under test, plus one
    logic [1:0]  w_lvl_sel; // level compared in this cycle
    logic [2:0]  w_count;
    logic [31:0] w_thr_sq;

    assign w_count   = (i_level_count > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : i_level_count;
    assign w_lvl_sel = r_lvl_idx[1:0] - 2'd1;
    assign w_thr_sq  = i_thr[w_lvl_sel] * i_thr[w_lvl_sel];

    assign o_stall     = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_OUT);
    assign o_job       = r_job;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_SQ;
            F_SQ:   n_state = F_CMP;
            F_CMP:  if (r_lvl_idx >= w_count || r_lvl_idx == 3'd4) n_state = F_OUT;
            F_OUT:  if (!i_job_stall) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload: capture, square, sum, then one threshold compare a cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_job.index       <= i_object_index;
                r_job.active      <= i_group_visible &&
                                     ({26'd0, i_object_index} < 32'(MAX_OBJECTS));
                r_job.has_level   <= 1'b0;
                r_job.level       <= 2'd0;
                r_job.mesh_level  <= 1'b0;
                r_job.now_ms      <= i_now_ms;
                r_job.is_animated <= i_is_animated;
                r_job.material    <= i_object_material;
                r_dx <= 17'(i_object_x) - 17'(i_camera_x);
                r_dy <= 17'(i_object_y) - 17'(i_camera_y);
                r_dz <= 17'(i_object_z) - 17'(i_camera_z);
                r_lvl_idx <= 3'd0;
            end
            F_SQ: begin
                r_sq[0] <= $unsigned(34'(r_dx) * 34'(r_dx));
                r_sq[1] <= $unsigned(34'(r_dy) * 34'(r_dy));
                r_sq[2] <= $unsigned(34'(r_dz) * 34'(r_dz));
            end
            F_CMP: begin
                if (r_lvl_idx == 3'd0) begin
                    r_d2 <= 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2]);
                end else if (r_d2 >= 36'(w_thr_sq) && r_lvl_idx <= w_count) begin
                    r_job.has_level  <= 1'b1;
                    r_job.level      <= w_lvl_sel;
                    r_job.mesh_level <= i_mesh_mask[w_lvl_sel];
                end
                r_lvl_idx <= r_lvl_idx + 3'd1;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/lsfc_queue.sv -----
// Two-entry queue between the front and back parts.
module lsfc_queue
    import lsfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_job o_job
);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_job;
    end

endmodule

// ----- sv/lsfc_back.sv -----
// Back part: per-object state, iterative fade division and result forming.
module lsfc_back
    import lsfc_pkg::*;
#(
    parameter int MAX_OBJECTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_stall,
    input  t_job        i_job,
    input  logic [15:0] i_fade_scale,
    input  logic        i_alpha_en,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int SW = 2 + 32 + 2 + 5;  // mode, start, level, material

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_DONE  = 3'd4;
    localparam logic [2:0] B_OUT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    t_job          r_job;
    logic [SW-1:0] w_rdata, w_wdata;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [1:0]    r_mode;
    logic [31:0]   r_start;
    logic [1:0]    r_level;
    logic [4:0]    r_mat;
    // Restoring divider: remainder and quotient bits.
    logic [32:0]   r_rem;
    logic [31:0]   r_quo;
    logic [5:0]    r_bit;
    logic [32:0]   w_trial;
    t_result       r_res;

    assign w_addr = (r_state == B_CLEAR) ? r_clr_addr : AW'(i_job.index);

    lsfc_ram #(.WIDTH(SW), .DEPTH(MAX_OBJECTS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  ((r_state == B_CLEAR || r_state == B_IDLE) ? w_addr : AW'(r_job.index)),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_job_stall = (r_state != B_IDLE);
    assign o_valid     = (r_state == B_OUT);
    assign o_result    = r_res;
    assign w_trial     = {r_rem[31:0], r_quo[31]} - {17'd0, i_fade_scale};

    // Fade byte and state update, settled from the division result.
    logic [7:0]    w_fade;
    logic [7:0]    w_fade_out;
    logic [31:0]   w_rev;
    logic [1:0]    w_mode;
    logic [31:0]   w_start;
    logic [1:0]    w_lvl;
    logic [4:0]    w_mat;
    t_result       w_res;
    logic [31:0]   w_col;
    logic          w_fire;

    assign w_fade = (i_fade_scale == 16'd0 || r_quo > 32'd255) ? FADE_FULL : r_quo[7:0];
    // A fade-out that starts now has no elapsed time yet.
    assign w_fade_out = (r_mode != MODE_OPAQUE) ? w_fade :
                        (i_fade_scale == 16'd0) ? FADE_FULL : 8'd0;
    assign w_rev  = r_job.now_ms - (32'(FADE_FULL) * 32'(i_fade_scale)
                    - (r_job.now_ms - r_start));

    always_comb begin
        w_mode  = r_mode;
        w_start = r_start;
        w_lvl   = r_level;
        w_mat   = r_mat;
        w_col   = 32'd0;
        w_res   = '0;
        w_res.index = r_job.index;
        if (r_job.active) begin
            if (r_job.has_level && !r_job.mesh_level) begin
                if (r_mode == MODE_OPAQUE) begin
                    w_mode = MODE_FADE_OUT;
                    w_start = r_job.now_ms;
                    w_mat = r_job.material;
                    w_res.mat_action = MAT_FADE;
                    w_res.mat_value = r_job.material;
                end
                if (w_mode == MODE_FADE_OUT) begin
                    if (w_fade_out == FADE_FULL) begin
                        w_res.vis_action = VIS_HIDE;
                        w_mode = MODE_INVISIBLE;
                        w_res.notify = NOTE_HIDDEN;
                    end
                    w_res.write_color = 1'b1;
                    w_col = ALL_ONES - 32'(w_fade_out) * BYTE_REPLICATE;
                end else if (w_mode == MODE_FADE_IN) begin
                    w_start = w_rev;
                    w_mode = MODE_FADE_OUT;
                end
            end else begin
                if (r_job.has_level && r_job.level != r_level) begin
                    w_lvl = r_job.level;
                    if (r_job.is_animated) begin
                        w_res.swap_mesh = 1'b1;
                        w_res.new_level = r_job.level;
                    end
                end
                if (r_mode == MODE_INVISIBLE) begin
                    w_res.vis_action = VIS_SHOW;
                    w_mode = MODE_FADE_IN;
                    w_start = r_job.now_ms;
                    if (!r_job.has_level) w_res.notify = NOTE_SHOWN;
                end else if (r_mode == MODE_FADE_IN) begin
                    if (w_fade == FADE_FULL) begin
                        w_res.mat_action = MAT_RESTORE;
                        w_res.mat_value = r_mat;
                        w_mode = MODE_OPAQUE;
                        if (r_job.has_level) w_res.notify = NOTE_SHOWN;
                    end
                    w_res.write_color = 1'b1;
                    w_col = 32'(w_fade) * BYTE_REPLICATE;
                end else if (r_mode == MODE_FADE_OUT) begin
                    w_start = w_rev;
                    w_mode = MODE_FADE_IN;
                end
            end
        end
        w_res.color = i_alpha_en ? w_col : (w_col & RGB_MASK);
    end

    assign w_fire  = (r_state == B_DONE);
    assign w_we    = (r_state == B_CLEAR) || (w_fire && r_job.active);
    assign w_wdata = (r_state == B_CLEAR) ? '0 : {w_mode, w_start, w_lvl, w_mat};

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_clr_addr == AW'(MAX_OBJECTS - 1)) n_state = B_IDLE;
            B_IDLE:  if (i_job_valid) n_state = B_READ;
            B_READ:  n_state = B_DIV;
            B_DIV:   if (r_bit == 6'd32) n_state = B_DONE;
            B_DONE:  n_state = B_OUT;
            B_OUT:   if (!i_stall) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Datapath: read state, divide one bit a cycle, then form the result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: r_job <= i_job;
            B_READ: begin
                {r_mode, r_start, r_level, r_mat} <= w_rdata;
                r_rem <= 33'd0;
                r_quo <= r_job.now_ms - w_rdata[SW-3 -: 32];
                r_bit <= 6'd0;
            end
            B_DIV: begin
                if (r_bit != 6'd32) begin
                    if (!w_trial[32]) begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_quo[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_bit <= r_bit + 6'd1;
                end
            end
            B_DONE: r_res <= w_res;
            default: ;
        endcase
    end

endmodule

// ----- sv/lod_select_fade_controller_core.sv -----
// Top level of the level-of-detail selector and fade controller.
// Each word updates one tracked object and gives one result word. The front
// part does the distance calculation and level choice, stepping through the
// levels in use; the back part then runs the bit-serial division of elapsed
// time by fade_scale for the word. Neither part takes a new word before it is
// through with the last, and the two-entry queue between them lets the front
// part go on while the back part is busy or the output is stalled. After reset
// the back part clears the object state memory, one entry a cycle, before it
// takes a word.
module lod_select_fade_controller_core
    import lsfc_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int MAX_LEVELS  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_object_index,
    input  logic [31:0] i_now_ms,
    input  logic signed [15:0] i_camera_x,
    input  logic signed [15:0] i_camera_y,
    input  logic signed [15:0] i_camera_z,
    input  logic signed [15:0] i_object_x,
    input  logic signed [15:0] i_object_y,
    input  logic signed [15:0] i_object_z,
    input  logic        i_is_animated,
    input  logic [4:0]  i_object_material,
    input  logic        i_group_visible,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_result_index,
    output logic        o_swap_mesh,
    output logic [1:0]  o_new_level,
    output logic [1:0]  o_visibility_action,
    output logic        o_write_color,
    output logic [31:0] o_color,
    output logic [1:0]  o_material_action,
    output logic [4:0]  o_material_value,
    output logic [1:0]  o_notify
);

    logic [15:0] r_thr [4];
    logic [3:0]  r_mesh_mask;
    logic [2:0]  r_level_cnt;
    logic [15:0] r_fade_scale;
    logic        r_alpha_en;
    logic        w_fj_valid, w_fj_stall, w_qb_valid, w_qb_stall;
    t_job        w_fj, w_qb;
    t_result     w_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= '{default: 16'd0};
            r_mesh_mask  <= 4'd0;
            r_level_cnt  <= 3'd0;
            r_fade_scale <= 16'd1;
            r_alpha_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THR0:       r_thr[0]     <= i_cfg_data;
                REG_THR1:       r_thr[1]     <= i_cfg_data;
                REG_THR2:       r_thr[2]     <= i_cfg_data;
                REG_THR3:       r_thr[3]     <= i_cfg_data;
                REG_MESH_MASK:  r_mesh_mask  <= i_cfg_data[3:0];
                REG_LEVEL_CNT:  r_level_cnt  <= i_cfg_data[2:0];
                REG_FADE_SCALE: r_fade_scale <= i_cfg_data;
                REG_ALPHA_EN:   r_alpha_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lsfc_front #(.MAX_OBJECTS(MAX_OBJECTS), .MAX_LEVELS(MAX_LEVELS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_object_index, .i_now_ms,
        .i_camera_x, .i_camera_y, .i_camera_z,
        .i_object_x, .i_object_y, .i_object_z,
        .i_is_animated, .i_object_material, .i_group_visible,
        .i_thr (r_thr), .i_mesh_mask (r_mesh_mask), .i_level_count (r_level_cnt),
        .o_job_valid (w_fj_valid), .i_job_stall (w_fj_stall), .o_job (w_fj)
    );

    lsfc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (w_fj_valid), .o_stall (w_fj_stall), .i_job (w_fj),
        .o_valid (w_qb_valid), .i_stall (w_qb_stall), .o_job (w_qb)
    );

    lsfc_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid (w_qb_valid), .o_job_stall (w_qb_stall), .i_job (w_qb),
        .i_fade_scale (r_fade_scale), .i_alpha_en (r_alpha_en),
        .o_valid, .i_stall, .o_result (w_res)
    );

    assign o_result_index      = w_res.index;
    assign o_swap_mesh         = w_res.swap_mesh;
    assign o_new_level         = w_res.new_level;
    assign o_visibility_action = w_res.vis_action;
    assign o_write_color       = w_res.write_color;
    assign o_color             = w_res.color;
    assign o_material_action   = w_res.mat_action;
    assign o_material_value    = w_res.mat_value;
    assign o_notify            = w_res.notify;

endmodule

// ----- sv/lsfc_checker.sv -----
// Port checker for the fade controller, bound to the top level.
module lsfc_checker
    import lsfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_swap_mesh,
    input logic [1:0]  o_new_level,
    input logic        o_write_color,
    input logic [31:0] o_color,
    input logic [1:0]  o_material_action,
    input logic [4:0]  o_material_value
);

    // A stalled result word stays valid and keeps its colour.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_color))
        else $error("result changed while stalled");

    // No mesh level without a swap.
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_swap_mesh |-> o_new_level == 2'd0)
        else $error("new level without swap");

    // Colour is zero when it is not written.
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_color |-> o_color == 32'd0)
        else $error("colour without write");

    // Material value is zero without a material action.
    a_mat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_material_action == MAT_NONE |-> o_material_value == 5'd0)
        else $error("material value without action");

endmodule

bind lod_select_fade_controller_core lsfc_checker u_checker (.*);

// ----- bench/tb_lod_select_fade_controller_core.sv -----
// Self-checking testbench for the level-of-detail selector and fade controller.
module tb_lod_select_fade_controller_core;
    import lsfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_OBJ       = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 60;

    // One update word as seen on the input ports.
    typedef struct {
        logic [5:0]         index;
        logic [31:0]        now_ms;
        logic signed [15:0] cx, cy, cz, ox, oy, oz;
        logic               animated;
        logic [4:0]         material;
        logic               group_vis;
    } t_update;

    // Row of the directed table: either a register write or an update word.
    typedef struct {
        bit        is_cfg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        t_update   upd;
        bit        has_exp;
        t_result   exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [5:0]  i_object_index = '0;
    logic [31:0] i_now_ms = '0;
    logic signed [15:0] i_camera_x = '0, i_camera_y = '0, i_camera_z = '0;
    logic signed [15:0] i_object_x = '0, i_object_y = '0, i_object_z = '0;
    logic        i_is_animated = 1'b0;
    logic [4:0]  i_object_material = '0;
    logic        i_group_visible = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_result_index;
    logic        o_swap_mesh;
    logic [1:0]  o_new_level;
    logic [1:0]  o_visibility_action;
    logic        o_write_color;
    logic [31:0] o_color;
    logic [1:0]  o_material_action;
    logic [4:0]  o_material_value;
    logic [1:0]  o_notify;

    // Typed expectation travelling alongside a directed word.
    logic        dir_has_exp = 1'b0;
    t_result     dir_exp = '0;

    lod_select_fade_controller_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of configuration and per-object state.
    logic [15:0] thr_q [4];
    logic [3:0]  mesh_mask_q;
    logic [2:0]  lvl_count_q;
    logic [15:0] scale_q;
    logic        alpha_q;
    logic [1:0]  obj_mode [N_OBJ];
    logic [31:0] obj_start [N_OBJ];
    logic [1:0]  obj_level [N_OBJ];
    logic [4:0]  obj_saved [N_OBJ];

    t_result     pending_results[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    t_row        dir_rows[$];

    initial begin
        for (int k = 0; k < 4; k++) thr_q[k] = '0;
        mesh_mask_q = '0;
        lvl_count_q = '0;
        scale_q = 16'd1;
        alpha_q = 1'b1;
        for (int k = 0; k < N_OBJ; k++) begin
            obj_mode[k] = MODE_OPAQUE;
            obj_start[k] = '0;
            obj_level[k] = '0;
            obj_saved[k] = '0;
        end
    end

    function automatic logic [31:0] fade_step(logic [31:0] now, logic [31:0] start);
        logic [31:0] q;
        // A zero scale gives a full fade at once.
        if (scale_q == 16'd0) return 32'd255;
        q = (now - start) / {16'd0, scale_q};
        return (q > 32'd255) ? 32'd255 : q;
    endfunction

    function automatic logic [31:0] mirrored_start(logic [31:0] now, logic [31:0] start);
        return now - (32'd255 * {16'd0, scale_q} - (now - start));
    endfunction

    function automatic logic [31:0] masked_color(logic [31:0] w);
        return alpha_q ? w : (w & RGB_MASK);
    endfunction

    // Works out the result of one update and advances the object state.
    function automatic t_result update_object(t_update u);
        t_result     r;
        longint      dx, dy, dz, d2;
        int          lv, cnt;
        logic [1:0]  md;
        logic [31:0] st, f;
        int          ix;
        r = '0;
        r.index = u.index;
        if (!u.group_vis) return r;
        ix = u.index;
        dx = longint'(u.ox) - longint'(u.cx);
        dy = longint'(u.oy) - longint'(u.cy);
        dz = longint'(u.oz) - longint'(u.cz);
        d2 = dx * dx + dy * dy + dz * dz;
        cnt = (lvl_count_q > 4) ? 4 : lvl_count_q;
        lv = -1;
        for (int j = 0; j < cnt; j++)
            if (d2 >= longint'(thr_q[j]) * longint'(thr_q[j])) lv = j;
        md = obj_mode[ix];
        st = obj_start[ix];
        if (lv >= 0 && !mesh_mask_q[lv]) begin
            // Fade-out level.
            if (md == MODE_OPAQUE) begin
                md = MODE_FADE_OUT;
                st = u.now_ms;
                obj_saved[ix] = u.material;
                r.mat_action = MAT_FADE;
                r.mat_value = u.material;
            end
            if (md == MODE_FADE_OUT) begin
                f = fade_step(u.now_ms, st);
                if (f == 32'd255) begin
                    r.vis_action = VIS_HIDE;
                    md = MODE_INVISIBLE;
                    r.notify = NOTE_HIDDEN;
                end
                r.write_color = 1'b1;
                r.color = masked_color(ALL_ONES - f * BYTE_REPLICATE);
            end else if (md == MODE_FADE_IN) begin
                st = mirrored_start(u.now_ms, st);
                md = MODE_FADE_OUT;
            end
        end else begin
            // Mesh level or no level at all: fade back in.
            if (lv >= 0 && lv[1:0] != obj_level[ix]) begin
                obj_level[ix] = lv[1:0];
                if (u.animated) begin
                    r.swap_mesh = 1'b1;
                    r.new_level = lv[1:0];
                end
            end
            if (md == MODE_INVISIBLE) begin
                r.vis_action = VIS_SHOW;
                md = MODE_FADE_IN;
                st = u.now_ms;
                if (lv < 0) r.notify = NOTE_SHOWN;
            end else if (md == MODE_FADE_IN) begin
                f = fade_step(u.now_ms, st);
                if (f == 32'd255) begin
                    r.mat_action = MAT_RESTORE;
                    r.mat_value = obj_saved[ix];
                    md = MODE_OPAQUE;
                    if (lv >= 0) r.notify = NOTE_SHOWN;
                end
                r.write_color = 1'b1;
                r.color = masked_color(f * BYTE_REPLICATE);
            end else if (md == MODE_FADE_OUT) begin
                st = mirrored_start(u.now_ms, st);
                md = MODE_FADE_IN;
            end
        end
        obj_mode[ix] = md;
        obj_start[ix] = st;
        return r;
    endfunction

    // Predict on every accepted word, check every accepted result.
    always @(posedge i_clk) begin
        t_update u;
        t_result p, g;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) begin
            u.index = i_object_index;
            u.now_ms = i_now_ms;
            u.cx = i_camera_x; u.cy = i_camera_y; u.cz = i_camera_z;
            u.ox = i_object_x; u.oy = i_object_y; u.oz = i_object_z;
            u.animated = i_is_animated;
            u.material = i_object_material;
            u.group_vis = i_group_visible;
            p = update_object(u);
            if (dir_has_exp) p = dir_exp;
            pending_results = {pending_results, p};
        end
        if (i_rst_n && o_valid && !i_stall) begin
            g.index = o_result_index;
            g.swap_mesh = o_swap_mesh;
            g.new_level = o_new_level;
            g.vis_action = o_visibility_action;
            g.write_color = o_write_color;
            g.color = o_color;
            g.mat_action = o_material_action;
            g.mat_value = o_material_value;
            g.notify = o_notify;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", g);
            end else begin
                p = pending_results.pop_front();
                if (p !== g) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: expected %p, got %p", cycles, p, g);
                end
            end
        end
    end

    // Receiver stalls in randomly chosen modes that change periodically.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= (cycles[3:0] < 4'd5);
        endcase
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_THR0, REG_THR1, REG_THR2, REG_THR3: thr_q[idx[1:0]] = data;
            REG_MESH_MASK:  mesh_mask_q = data[3:0];
            REG_LEVEL_CNT:  lvl_count_q = data[2:0];
            REG_FADE_SCALE: scale_q = data;
            default:        alpha_q = data[0];
        endcase
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    int burst_left = 0;

    task automatic send_word(t_update u, bit has_exp, t_result exp);
        i_valid <= 1'b1;
        i_object_index <= u.index;
        i_now_ms <= u.now_ms;
        i_camera_x <= u.cx; i_camera_y <= u.cy; i_camera_z <= u.cz;
        i_object_x <= u.ox; i_object_y <= u.oy; i_object_z <= u.oz;
        i_is_animated <= u.animated;
        i_object_material <= u.material;
        i_group_visible <= u.group_vis;
        dir_has_exp <= has_exp;
        dir_exp <= exp;
        do @(posedge i_clk); while (o_stall);
        // Bursts of words separated by random gaps.
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            dir_has_exp <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_update on_axis(logic [5:0] idx, logic [31:0] now, int span,
                                        bit anim, logic [4:0] mat, bit vis);
        t_update u;
        u.index = idx; u.now_ms = now;
        u.cx = -16'sd32768; u.cy = 16'sd100; u.cz = -16'sd100;
        u.ox = 16'(-32768 + span); u.oy = 16'sd100; u.oz = -16'sd100;
        u.animated = anim; u.material = mat; u.group_vis = vis;
        return u;
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [15:0] data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.reg_idx = idx; r.reg_data = data;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_word(t_update u, bit has_exp, t_result exp);
        t_row r;
        r = '{default: '0};
        r.upd = u; r.has_exp = has_exp; r.exp = exp;
        dir_rows = {dir_rows, r};
    endfunction

    // Random update with a distance placed near one of the thresholds, or anywhere in range.
    function automatic t_update random_word(logic [31:0] now);
        t_update u;
        int d, j;
        j = $urandom_range(0, 4);
        if (j == 4) d = $urandom_range(0, 65535);
        else d = int'(thr_q[j]) + $urandom_range(0, 6) - 3;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        u = on_axis(6'($urandom_range(0, 5)), now, d, $urandom_range(0, 1),
                    5'($urandom), ($urandom_range(0, 15) != 0));
        u.cy = 16'($urandom_range(0, 40000) - 20000);
        u.oy = u.cy + 16'($urandom_range(0, 3));
        u.cz = 16'($urandom_range(0, 40000) - 20000);
        u.oz = u.cz - 16'($urandom_range(0, 3));
        return u;
    endfunction

    initial begin
        t_result z, e;
        t_update u;
        logic [31:0] clock_ms;
        int n_phase;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, each fade path, extremes, hidden group.
        z = '0;
        e = z; e.index = 6'd0;
        add_word(on_axis(6'd0, 32'd0, 0, 1'b1, 5'd3, 1'b1), 1'b1, e);
        e = z; e.index = 6'd63;
        u = on_axis(6'd63, ALL_ONES, 65535, 1'b1, 5'h1F, 1'b0);
        add_word(u, 1'b1, e);
        add_reg(REG_THR0, 16'd0);
        add_reg(REG_THR1, 16'd100);
        add_reg(REG_THR2, 16'd65535);
        add_reg(REG_THR3, 16'd65535);
        add_reg(REG_MESH_MASK, 16'hD);
        add_reg(REG_LEVEL_CNT, 16'd4);
        add_reg(REG_FADE_SCALE, 16'd1);
        add_reg(REG_ALPHA_EN, 16'd1);
        // First step of a fade-out saves the material and writes full colour.
        e = z; e.index = 6'd1; e.write_color = 1'b1; e.color = ALL_ONES;
        e.mat_action = MAT_FADE; e.mat_value = 5'h1F;
        add_word(on_axis(6'd1, 32'd1000, 200, 1'b0, 5'h1F, 1'b1), 1'b1, e);
        add_word(on_axis(6'd1, 32'd1100, 200, 1'b0, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd1150, 10, 1'b1, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd1300, 10, 1'b1, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd2000, 200, 1'b0, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd5000, 200, 1'b0, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd5100, 10, 1'b1, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd1, 32'd6000, 10, 1'b1, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd2, 32'd7000, 200, 1'b0, 5'h0A, 1'b1), 1'b0, z);
        add_word(on_axis(6'd2, 32'd9000, 200, 1'b0, 5'h15, 1'b1), 1'b0, z);
        // Furthest corners of the coordinate space pick the top level.
        u = on_axis(6'd3, 32'd9100, 0, 1'b1, 5'd0, 1'b1);
        u.cy = -16'sd32768; u.cz = -16'sd32768;
        u.ox = 16'sd32767; u.oy = 16'sd32767; u.oz = 16'sd32767;
        add_word(u, 1'b0, z);
        // Raising the first threshold leaves a near object with no level.
        add_reg(REG_THR0, 16'd50);
        add_word(on_axis(6'd2, 32'd9200, 10, 1'b0, 5'h00, 1'b1), 1'b0, z);
        add_word(on_axis(6'd2, 32'd9900, 10, 1'b0, 5'h00, 1'b1), 1'b0, z);
        add_reg(REG_ALPHA_EN, 16'd0);
        e = z; e.index = 6'd4; e.write_color = 1'b1; e.color = RGB_MASK;
        e.mat_action = MAT_FADE; e.mat_value = 5'h11;
        add_word(on_axis(6'd4, 32'd10000, 200, 1'b1, 5'h11, 1'b1), 1'b1, e);
        add_reg(REG_FADE_SCALE, 16'hFFFF);
        add_word(on_axis(6'd4, 32'hFFFF_FFFF, 200, 1'b1, 5'h11, 1'b1), 1'b0, z);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                if (i_valid) begin
                    i_valid <= 1'b0;
                    dir_has_exp <= 1'b0;
                    @(posedge i_clk);
                end
                drain();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            end else begin
                send_word(dir_rows[k].upd, dir_rows[k].has_exp, dir_rows[k].exp);
            end
        end

        // Random phases, each under its own register setting.
        clock_ms = 32'hFFFF_0000;
        for (int ph = 0; ph < 6; ph++) begin
            i_valid <= 1'b0;
            dir_has_exp <= 1'b0;
            @(posedge i_clk);
            drain();
            case (ph)
                0: begin
                    write_reg(REG_THR0, 16'd0);    write_reg(REG_THR1, 16'd300);
                    write_reg(REG_THR2, 16'd1000); write_reg(REG_THR3, 16'd5000);
                    write_reg(REG_MESH_MASK, 16'h5); write_reg(REG_LEVEL_CNT, 16'd4);
                    write_reg(REG_FADE_SCALE, 16'd1); write_reg(REG_ALPHA_EN, 16'd1);
                end
                1: begin
                    write_reg(REG_MESH_MASK, 16'hF); write_reg(REG_FADE_SCALE, 16'd3);
                    write_reg(REG_ALPHA_EN, 16'd0);
                end
                2: begin
                    write_reg(REG_MESH_MASK, 16'h0); write_reg(REG_LEVEL_CNT, 16'd0);
                end
                3: begin
                    write_reg(REG_THR0, 16'd200);   write_reg(REG_THR3, 16'hFFFF);
                    write_reg(REG_MESH_MASK, 16'h9); write_reg(REG_LEVEL_CNT, 16'd3);
                    write_reg(REG_FADE_SCALE, 16'd2); write_reg(REG_ALPHA_EN, 16'd1);
                end
                4: begin
                    write_reg(REG_MESH_MASK, 16'h6); write_reg(REG_LEVEL_CNT, 16'd4);
                    write_reg(REG_FADE_SCALE, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_THR1, 16'd0);     write_reg(REG_MESH_MASK, 16'hA);
                    write_reg(REG_LEVEL_CNT, 16'd2); write_reg(REG_FADE_SCALE, 16'd1);
                end
            endcase
            for (int n = 0; n < 115; n++) begin
                if (ph == 2 && n == 60) begin
                    // Hold off until the block has nothing outstanding.
                    i_valid <= 1'b0;
                    dir_has_exp <= 1'b0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 19) == 0) begin
                    // Noise: every field random.
                    u.index = 6'($urandom); u.now_ms = $urandom;
                    u.cx = 16'($urandom); u.cy = 16'($urandom); u.cz = 16'($urandom);
                    u.ox = 16'($urandom); u.oy = 16'($urandom); u.oz = 16'($urandom);
                    u.animated = $urandom_range(0, 1); u.material = 5'($urandom);
                    u.group_vis = $urandom_range(0, 1);
                end else begin
                    if (scale_q == 16'hFFFF && $urandom_range(0, 3) == 0)
                        clock_ms += $urandom_range(0, 32'h00FF_FFFF);
                    else
                        clock_ms += $urandom_range(0, 24 * (scale_q > 16'd8 ? 8 : scale_q));
                    u = random_word(clock_ms);
                end
                send_word(u, 1'b0, z);
            end
        end

        i_valid <= 1'b0;
        dir_has_exp <= 1'b0;
        @(posedge i_clk);
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
